// ===== rtl/mqsfl_pkg.sv =====
// Shared types, codes and defaults for the multi-queue shared free list block.
`timescale 1ns / 1ps

package mqsfl_pkg;

	localparam int DATA_W = 32;
	localparam int QID_W = 2;
	localparam int ST_W = 2;

	localparam int SLOTS_DEF = 16;
	localparam int QUEUES_DEF = 4;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic fetch;
		logic commit;
	} mqsfl_cmd_t;

endpackage

// ===== rtl/multi_queue_shared_free_list_top.sv =====
// Top level of the multi-queue shared free list block.
`timescale 1ns / 1ps

// Several FIFO queues share one store of SLOTS data slots. Each queue is a linked
// list of slots with its own head and tail, and unused slots form a free list.
// An enqueue transaction takes the slot at the head of the free list, writes the
// data word into it and links it after the queue's tail; with no slot free it
// returns status full and changes nothing. A dequeue transaction unlinks the
// queue's head slot, returns its word and pushes the slot onto the front of the
// free list; on an empty queue it returns status empty and a zero word. A queue
// number at or above QUEUES is ignored and reports full or empty. Every input
// transaction yields exactly one output transaction, in order. An enqueue goes
// from the idle state straight to the execute state, which commits its result
// into the output register; a dequeue passes through a fetch state first, because
// the dequeue must first read the queue's head slot from the head table before it
// can read that slot's link and data words from the link and data memories.
// The block works on one transaction at a time; the result sits in an output register,
// so a new transaction is accepted while an earlier result waits to be taken, and
// its result is committed once the earlier one has left.
// There is no clearing pass after reset: slots that were never handed out are
// tracked with a fill count, and their links follow the initial chain.

module multi_queue_shared_free_list_top #(
	parameter int SLOTS = mqsfl_pkg::SLOTS_DEF,
	parameter int QUEUES = mqsfl_pkg::QUEUES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 kind,
	input  logic [mqsfl_pkg::QID_W-1:0]          queue_id,
	input  logic signed [mqsfl_pkg::DATA_W-1:0]  push_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [mqsfl_pkg::DATA_W-1:0] pop_value,
	output logic [mqsfl_pkg::ST_W-1:0]           status
);
	import mqsfl_pkg::*;

	// Command bundle from the controller to the datapath.
	mqsfl_cmd_t cmd;

	mqsfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_kind   (kind),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	mqsfl_dp #(
		.SLOTS  (SLOTS),
		.QUEUES (QUEUES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind),
		.queue_id   (queue_id),
		.push_value (push_value),
		.pop_value  (pop_value),
		.status     (status)
	);

endmodule

// ===== rtl/mqsfl_ctrl.sv =====
// Sequencing state machine: accept, optional head fetch, commit into the output register.
`timescale 1ns / 1ps

module mqsfl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_kind,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output mqsfl_pkg::mqsfl_cmd_t cmd
);
	import mqsfl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture = in_valid && (state_q == S_IDLE);
		cmd.fetch = (state_q == S_FETCH);
		cmd.commit = (state_q == S_EXEC) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (in_kind == KIND_DEQ) ? S_FETCH : S_EXEC;
					end
				end
				S_FETCH: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/mqsfl_dp.sv =====
// Datapath: head and tail tables, link and data memories, free list and result register.
`timescale 1ns / 1ps

module mqsfl_dp #(
	parameter int SLOTS = mqsfl_pkg::SLOTS_DEF,
	parameter int QUEUES = mqsfl_pkg::QUEUES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mqsfl_pkg::mqsfl_cmd_t                cmd,
	input  logic                                 kind,
	input  logic [mqsfl_pkg::QID_W-1:0]          queue_id,
	input  logic signed [mqsfl_pkg::DATA_W-1:0]  push_value,
	output logic signed [mqsfl_pkg::DATA_W-1:0] pop_value,
	output logic [mqsfl_pkg::ST_W-1:0]           status
);
	import mqsfl_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

	// Queue tables and link/data stores.
	logic [SW-1:0]     head_mem [QUEUES];
	logic [SW-1:0]     tail_mem [QUEUES];
	logic [SW:0]       link_mem [SLOTS];
	logic [DATA_W-1:0] data_mem [SLOTS];

	logic [QUEUES-1:0] head_valid_q;
	logic              free_valid_q;
	logic [SW-1:0]     free_head_q;
	logic [SW:0]       fresh_q;

	// Latched transaction.
	logic              kind_q;
	logic [QW-1:0]     qid_q;
	logic              in_range_q;
	logic              hv_q;
	logic [DATA_W-1:0] value_q;

	// Registered read data.
	logic [SW-1:0]     head_rd_q;
	logic [SW-1:0]     tail_rd_q;
	logic [SW:0]       link_rd_q;
	logic [SW-1:0]     link_addr_q;
	logic [DATA_W-1:0] data_rd_q;

	logic [DATA_W-1:0] pop_value_q;
	logic [ST_W-1:0]   status_q;

	logic [8:0]        qid_wide;
	logic [QW-1:0]     in_addr;
	logic              in_range;
	logic [SW-1:0]     link_raddr;
	logic              link_eff_valid;
	logic [SW-1:0]     link_eff_idx;
	logic              enq_ok;
	logic              deq_ok;
	logic              deq_last;

	assign qid_wide = {7'd0, queue_id};
	assign in_addr = qid_wide[QW-1:0];
	assign in_range = (qid_wide < 9'(QUEUES));

	assign link_raddr = cmd.fetch ? head_rd_q : free_head_q;

	// Slots never handed out have no stored link; their reset chain is derived from the index.
	always_comb begin
		if ({1'b0, link_addr_q} < fresh_q) begin
			link_eff_valid = link_rd_q[SW];
			link_eff_idx = link_rd_q[SW-1:0];
		end else begin
			link_eff_valid = (link_addr_q != LAST_SLOT);
			link_eff_idx = SW'(link_addr_q + 1'b1);
		end
	end

	assign enq_ok = in_range_q && free_valid_q;
	assign deq_ok = in_range_q && hv_q;
	// A tail slot's link is never cleared, so the last element is found by head equals tail.
	assign deq_last = (head_rd_q == tail_rd_q) || !link_eff_valid;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			qid_q <= in_addr;
			in_range_q <= in_range;
			hv_q <= in_range ? head_valid_q[in_addr] : 1'b0;
			value_q <= push_value;
			head_rd_q <= head_mem[in_addr];
			tail_rd_q <= tail_mem[in_addr];
		end
		if (cmd.capture || cmd.fetch) begin
			link_rd_q <= link_mem[link_raddr];
			link_addr_q <= link_raddr;
		end
		if (cmd.fetch) begin
			data_rd_q <= data_mem[head_rd_q];
		end
		if (cmd.commit) begin
			if (kind_q == KIND_ENQ) begin
				pop_value_q <= '0;
				status_q <= enq_ok ? ST_OK : ST_FULL;
				if (enq_ok) begin
					if (hv_q) begin
						link_mem[tail_rd_q] <= {1'b1, free_head_q};
					end else begin
						head_mem[qid_q] <= free_head_q;
					end
					tail_mem[qid_q] <= free_head_q;
					data_mem[free_head_q] <= value_q;
				end
			end else begin
				pop_value_q <= deq_ok ? data_rd_q : '0;
				status_q <= deq_ok ? ST_OK : ST_EMPTY;
				if (deq_ok) begin
					head_mem[qid_q] <= link_eff_idx;
					link_mem[head_rd_q] <= {free_valid_q, free_head_q};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= '0;
			free_valid_q <= 1'b1;
			free_head_q <= '0;
			fresh_q <= '0;
		end else if (cmd.commit) begin
			if (kind_q == KIND_ENQ) begin
				if (enq_ok) begin
					free_valid_q <= link_eff_valid;
					free_head_q <= link_eff_idx;
					if (!hv_q) begin
						head_valid_q[qid_q] <= 1'b1;
					end
					if ({1'b0, free_head_q} == fresh_q) begin
						fresh_q <= fresh_q + 1'b1;
					end
				end
			end else if (deq_ok) begin
				head_valid_q[qid_q] <= !deq_last;
				free_valid_q <= 1'b1;
				free_head_q <= head_rd_q;
			end
		end
	end

	assign pop_value = pop_value_q;
	assign status = status_q;

endmodule

// ===== rtl/mqsfl_checker.sv =====
// Port-level checker for the multi-queue shared free list block, with its bind.
`timescale 1ns / 1ps

module mqsfl_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic signed [mqsfl_pkg::DATA_W-1:0]  pop_value,
	input logic [mqsfl_pkg::ST_W-1:0]           status
);
	import mqsfl_pkg::*;

	// A waiting result holds still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pop_value) && $stable(status))
		else $error("result changed while stalled");

	// Only the three defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
		else $error("undefined status code");

	// A failed transaction returns a zero word.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> pop_value == '0)
		else $error("nonzero word on failed transaction");

	// One transaction at a time: no acceptance in the cycle after an acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

endmodule

bind multi_queue_shared_free_list_top mqsfl_checker u_mqsfl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pop_value (pop_value),
	.status    (status)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the multi-queue shared free list block.
`timescale 1ns / 1ps

module tb;

	import mqsfl_pkg::*;

	// The predictor is sized like the block's default build.
	localparam int SLOTS = SLOTS_DEF;
	localparam int QUEUES = QUEUES_DEF;
	localparam int SLOT_W = $clog2(SLOTS);

	// Run shaping. The random part is split into phases, and each phase leans
	// toward enqueues or dequeues so that queues fill up, overflow and drain.
	localparam int RANDOM_OPS = 800;
	localparam int PHASE_LEN = 40;
	localparam int CALM_TAIL = 100;
	localparam int PAUSE_AT = 550;
	localparam int HOLD_AT = 300;
	localparam int HOLD_LEN = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic kind;
		logic [QID_W-1:0] queue_id;
		logic signed [DATA_W-1:0] push_value;
	} queue_op_t;

	typedef struct {
		logic signed [DATA_W-1:0] pop_value;
		logic [ST_W-1:0] status;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic kind = KIND_ENQ;
	logic [QID_W-1:0] queue_id = '0;
	logic signed [DATA_W-1:0] push_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DATA_W-1:0] pop_value;
	logic [ST_W-1:0] status;

	// Operations waiting to be offered, and results the block still owes us.
	queue_op_t pending_ops[$];
	queue_result_t awaited_results[$];

	int total_ops = 0;
	int ops_accepted = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// Predictor state. A cleared valid bit stands for a null link.
	logic [QUEUES-1:0] head_ok;
	logic [SLOT_W-1:0] head_slot[QUEUES];
	logic [SLOT_W-1:0] tail_slot[QUEUES];
	logic [SLOTS-1:0] link_ok;
	logic [SLOT_W-1:0] link_slot[SLOTS];
	logic [DATA_W-1:0] slot_word[SLOTS];
	logic free_ok;
	logic [SLOT_W-1:0] free_slot;

	multi_queue_shared_free_list_top #(
		.SLOTS(SLOTS),
		.QUEUES(QUEUES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.queue_id(queue_id),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pop_value(pop_value),
		.status(status)
	);

	always #5 clk = ~clk;

	// After reset every queue is empty and all slots are chained into the free
	// list in index order, starting at slot zero.
	function automatic void clear_queues();
		for (int i = 0; i < QUEUES; i++) begin
			head_ok[i] = 1'b0;
			head_slot[i] = '0;
			tail_slot[i] = '0;
		end
		for (int i = 0; i < SLOTS; i++) begin
			link_ok[i] = (i + 1 < SLOTS);
			link_slot[i] = SLOT_W'(i + 1);
			slot_word[i] = '0;
		end
		free_ok = 1'b1;
		free_slot = '0;
	endfunction

	// Applies one operation to the predicted queue state and returns the
	// result the block must produce for it.
	function automatic queue_result_t predict_queue_op(queue_op_t op);
		queue_result_t res;
		logic [SLOT_W-1:0] s;
		int q;
		res.pop_value = '0;
		res.status = ST_OK;
		q = op.queue_id;
		if (op.kind == KIND_ENQ) begin
			if (q >= QUEUES || !free_ok) begin
				res.status = ST_FULL;
			end else begin
				// Take the slot at the front of the free list.
				s = free_slot;
				free_ok = link_ok[s];
				free_slot = link_ok[s] ? link_slot[s] : '0;
				// Hang it after the tail, or make it the head of an empty queue.
				if (!head_ok[q]) begin
					head_ok[q] = 1'b1;
					head_slot[q] = s;
				end else begin
					link_ok[tail_slot[q]] = 1'b1;
					link_slot[tail_slot[q]] = s;
				end
				link_ok[s] = 1'b0;
				link_slot[s] = '0;
				tail_slot[q] = s;
				slot_word[s] = op.push_value;
			end
		end else begin
			if (q >= QUEUES || !head_ok[q]) begin
				res.status = ST_EMPTY;
			end else begin
				// Unlink the head and push it onto the front of the free list.
				s = head_slot[q];
				head_ok[q] = link_ok[s];
				head_slot[q] = link_ok[s] ? link_slot[s] : '0;
				link_ok[s] = free_ok;
				link_slot[s] = free_ok ? free_slot : '0;
				free_ok = 1'b1;
				free_slot = s;
				res.pop_value = slot_word[s];
			end
		end
		return res;
	endfunction

	function automatic queue_op_t make_op(logic k, logic [QID_W-1:0] q,
			logic [DATA_W-1:0] v);
		queue_op_t op;
		op.kind = k;
		op.queue_id = q;
		op.push_value = v;
		return op;
	endfunction

	// Driver. A transaction is offered until it is accepted; between
	// transactions the sender may go quiet for a short random burst. Once,
	// after PAUSE_AT acceptances, it holds off until every result is back.
	int gap_left = 0;
	logic pause_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		queue_op_t op;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= KIND_ENQ;
			queue_id <= '0;
			push_value <= '0;
		end else begin
			if (in_valid && in_ready) begin
				awaited_results.push_back(predict_queue_op(make_op(kind, queue_id,
					push_value)));
				ops_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (!pause_done && ops_accepted == PAUSE_AT) begin
					if (awaited_results.size() == 0)
						pause_done = 1'b1;
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					op = pending_ops.pop_front();
					kind <= op.kind;
					queue_id <= op.queue_id;
					push_value <= op.push_value;
					in_valid <= 1'b1;
					// The gap, if any, follows this transaction's acceptance.
					if (pending_ops.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
						gap_left = $urandom_range(1, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Every result is checked against the oldest prediction. The
	// receiver stalls in short random bursts, and once, after HOLD_AT results,
	// it holds results back so that the block backs up and stops taking input.
	int stall_left = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		queue_result_t exp_res;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("Result with no transaction outstanding: pop_value=%0d status=%0d",
						pop_value, status);
					mismatch_count++;
				end else begin
					exp_res = awaited_results.pop_front();
					if (pop_value !== exp_res.pop_value) begin
						$error("pop_value mismatch: expected %0d, actual %0d",
							exp_res.pop_value, pop_value);
						mismatch_count++;
					end
					if (status !== exp_res.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							exp_res.status, status);
						mismatch_count++;
					end
				end
				results_checked++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && results_checked >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (results_checked < total_ops - CALM_TAIL
					&& $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [DATA_W-1:0] extremes[6];
		int enq_pct;
		clear_queues();
		extremes[0] = 32'h8000_0000;
		extremes[1] = 32'h7FFF_FFFF;
		extremes[2] = 32'h0000_0000;
		extremes[3] = 32'hFFFF_FFFF;
		extremes[4] = 32'h5555_5555;
		extremes[5] = 32'hAAAA_AAAA;

		// Directed part: dequeue from every empty queue, fill the whole store
		// across all queues, the first six words extreme, overflow it once, then
		// take one word back from each queue.
		for (int q = 0; q < QUEUES; q++)
			pending_ops.push_back(make_op(KIND_DEQ, QID_W'(q), $urandom));
		for (int i = 0; i < SLOTS; i++)
			pending_ops.push_back(make_op(KIND_ENQ, QID_W'(i % QUEUES),
				(i < 6) ? extremes[i] : $urandom));
		pending_ops.push_back(make_op(KIND_ENQ,
			QID_W'($urandom_range(0, QUEUES - 1)), $urandom));
		for (int q = QUEUES - 1; q >= 0; q--)
			pending_ops.push_back(make_op(KIND_DEQ, QID_W'(q), $urandom));

		// Random part, phase by phase, each with its own enqueue share.
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i % PHASE_LEN == 0) begin
				case ($urandom_range(0, 3))
					0: enq_pct = 15;
					1: enq_pct = 50;
					2: enq_pct = 70;
					default: enq_pct = 90;
				endcase
			end
			pending_ops.push_back(make_op(
				($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ,
				QID_W'($urandom_range(0, QUEUES - 1)),
				($urandom_range(0, 15) == 0) ? extremes[$urandom_range(0, 5)]
					: $urandom));
		end
		total_ops = pending_ops.size();

		// Reset is held, then released at a falling edge, away from the active edge.
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every transaction to be taken and answered, then watch a
		// little longer for stray results.
		wait (ops_accepted == total_ops);
		wait (awaited_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
